### src/echo_distance_smoothing_color_top_macros.svh
// Assertion macros for the echo distance smoothing color block.
// Used by echo_distance_smoothing_color_top; expects clk and rst in scope.
`ifndef ECHO_DISTANCE_SMOOTHING_COLOR_TOP_MACROS_SVH
`define ECHO_DISTANCE_SMOOTHING_COLOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define EDSC_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define EDSC_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/edsc_pkg.sv
// Shared types and constants for the echo distance smoothing color block.
// No dependencies.
package edsc_pkg;

  localparam int WIDTH_W    = 20;    // echo width input
  localparam int DIST_W     = 23;    // distance, 1/256 cm
  localparam int COLOR_W    = 8;
  localparam int EDGE_W     = 8;
  localparam int SCALE_W    = 11;
  localparam int PROD_W     = WIDTH_W + SCALE_W;
  localparam int FRAC_W     = 8;
  localparam int CM_W       = DIST_W - FRAC_W;
  localparam int RAMP_W     = 2 * EDGE_W;
  localparam int STEP_W     = 5;     // divider step count, up to 31
  localparam int CFG_IDX_W  = 3;
  localparam int DEF_WINDOW = 10;

  localparam logic [SCALE_W-1:0] SCALE_Q8 = 11'd1114;  // 0.017 cm/us in Q16

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_OFF    = 3'd0,
    REG_EDGE_RED    = 3'd1,
    REG_EDGE_RAMP   = 3'd2,
    REG_EDGE_YELLOW = 3'd3,
    REG_EDGE_GREEN  = 3'd4,
    REG_EDGE_BLUE   = 3'd5,
    REG_GREEN_PEAK  = 3'd6
  } cfg_reg_t;

  localparam logic [EDGE_W-1:0] RST_EDGE_OFF    = 8'd5;
  localparam logic [EDGE_W-1:0] RST_EDGE_RED    = 8'd11;
  localparam logic [EDGE_W-1:0] RST_EDGE_RAMP   = 8'd21;
  localparam logic [EDGE_W-1:0] RST_EDGE_YELLOW = 8'd29;
  localparam logic [EDGE_W-1:0] RST_EDGE_GREEN  = 8'd39;
  localparam logic [EDGE_W-1:0] RST_EDGE_BLUE   = 8'd50;
  localparam logic [EDGE_W-1:0] RST_GREEN_PEAK  = 8'd165;

  localparam logic [COLOR_W-1:0] LVL_ZERO     = 8'd0;
  localparam logic [COLOR_W-1:0] LVL_FULL     = 8'd255;
  localparam logic [COLOR_W-1:0] VIOLET_RB    = 8'd238;
  localparam logic [COLOR_W-1:0] VIOLET_G     = 8'd130;

  // divider launch
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

### src/echo_distance_smoothing_color_top.sv
// Echo distance smoothing color: echo width -> Q8 distance -> window average -> color.
// Depends on edsc_pkg, edsc_div and echo_distance_smoothing_color_top_macros.svh.
//
//   channel | signals                               | dir | beat
//   --------+---------------------------------------+-----+-------------------------------
//   in      | in_valid, in_stall, echo_width_us     | in  | in_valid & !in_stall
//   out     | out_valid, out_stall, smoothed_q8,    | out | out_valid & !out_stall
//           | red, green, blue                      |     |
//   cfg     | cfg_wen, cfg_idx, cfg_data            | in  | cfg_wen (index 7 ignored)
//
// One beat is worked on at a time. From accept to the edge that raises out_valid a beat
// passes ring read, sum update, reciprocal multiply for the average and band pick.
// The ramp band adds a launch, 16 bit-serial divide steps and the quotient pickup.
// The next beat can be taken in the cycle after hand-off. Reset clears the ring valid bits,
// slot, sum and handshake state and loads the config defaults at once; no clearing pass is
// needed. A new beat is taken while a result waits on out_stall; a second result then
// holds in the done state until the output register frees.
`include "echo_distance_smoothing_color_top_macros.svh"

module echo_distance_smoothing_color_top #(
  parameter int WINDOW = edsc_pkg::DEF_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [edsc_pkg::WIDTH_W-1:0]       echo_width_us,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [edsc_pkg::DIST_W-1:0]        smoothed_q8,
  output logic [edsc_pkg::COLOR_W-1:0]       red,
  output logic [edsc_pkg::COLOR_W-1:0]       green,
  output logic [edsc_pkg::COLOR_W-1:0]       blue,
  // config write port
  input  logic                               cfg_wen,
  input  logic [edsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [edsc_pkg::EDGE_W-1:0]        cfg_data
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = edsc_pkg::DIST_W + $clog2(WINDOW);  // never wraps
  localparam int DIST_W = edsc_pkg::DIST_W;
  localparam int CM_W   = edsc_pkg::CM_W;
  localparam int RAMP_W = edsc_pkg::RAMP_W;

  // sum / WINDOW as (sum * ceil(2^AVG_SH / WINDOW)) >> AVG_SH, exact for any SUM_W-bit sum
  localparam int AVG_SH     = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  typedef enum logic [2:0] {
    S_IDLE,    // wait for input beat; ring read issued on accept
    S_UPD,     // registered ring data back: update sum, write ring
    S_DAVG,    // reciprocal multiply for the window average
    S_BAND,    // pick band from the whole cm of the average
    S_RAMP,    // launch ramp divide (multiply feeds divider load)
    S_DRAMP,   // ramp divide running
    S_DONE     // hand result to output register
  } state_t;

  state_t state;

  // config registers
  logic [7:0] edge_off, edge_red, edge_ramp, edge_yellow, edge_green, edge_blue;
  logic [7:0] green_peak;

  // ring memory: sync write, sync read
  logic [DIST_W-1:0] ring [WINDOW];
  logic [WINDOW-1:0] ring_valid;   // entry never written reads as zero
  logic [DIST_W-1:0] rd_data;
  logic              rd_valid;
  logic              ring_we;

  logic [SLOT_W-1:0] write_slot;
  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W-1:0]  sum_next;
  logic [DIST_W-1:0] old_dist;

  logic [edsc_pkg::PROD_W-1:0] scale_prod;
  logic [DIST_W-1:0]           dist_q;
  logic [AVG_PROD_W-1:0]       avg_prod;

  // work registers
  logic [DIST_W-1:0]           avg_q;
  logic [7:0]                  red_q, grn_q, blu_q;
  logic [7:0]                  ramp_diff_q;
  logic [7:0]                  span_q;
  logic [RAMP_W-1:0]           ramp_prod;

  // divider hookup
  edsc_pkg::div_ctl_t  div_ctl;
  logic [RAMP_W-1:0]   div_dvd;
  logic [7:0]          div_dvs;
  logic [RAMP_W-1:0]   div_quo;
  logic                div_done;

  // band pick from whole cm of the average
  logic [CM_W-1:0]    cm;
  logic [7:0]         band_r, band_g, band_b;
  logic               band_ramp;

  logic in_acc;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // width * 1114 >> 8: Q8 centimetres for half the round trip at 0.034 cm/us
  assign scale_prod = edsc_pkg::PROD_W'(echo_width_us) *
                      edsc_pkg::PROD_W'(edsc_pkg::SCALE_Q8);

  assign old_dist  = rd_valid ? rd_data : '0;
  assign sum_next  = running_sum - SUM_W'(old_dist) + SUM_W'(dist_q);
  assign avg_prod  = AVG_PROD_W'(running_sum) * AVG_PROD_W'(AVG_RECIP);
  assign ramp_prod = RAMP_W'(ramp_diff_q) * RAMP_W'(green_peak);
  assign ring_we   = (state == S_UPD);

  // divider only serves the ramp fraction
  assign div_ctl.start = (state == S_RAMP);
  assign div_ctl.steps = edsc_pkg::STEP_W'(RAMP_W);
  assign div_dvd       = ramp_prod;
  assign div_dvs       = span_q;

  edsc_div #(
    .DVD_W (RAMP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .done     (div_done)
  );

  // bands tested lowest edge first; an empty band falls through
  assign cm = avg_q[DIST_W-1:edsc_pkg::FRAC_W];

  always_comb begin
    band_ramp = 1'b0;
    band_r    = edsc_pkg::VIOLET_RB;
    band_g    = edsc_pkg::VIOLET_G;
    band_b    = edsc_pkg::VIOLET_RB;
    if (cm < CM_W'(edge_off)) begin
      band_r = edsc_pkg::LVL_ZERO;
      band_g = edsc_pkg::LVL_ZERO;
      band_b = edsc_pkg::LVL_ZERO;
    end else if (cm < CM_W'(edge_red)) begin
      band_r = edsc_pkg::LVL_FULL;
      band_g = edsc_pkg::LVL_ZERO;
      band_b = edsc_pkg::LVL_ZERO;
    end else if (cm < CM_W'(edge_ramp)) begin
      band_ramp = 1'b1;           // green filled in by the ramp divide
      band_r    = edsc_pkg::LVL_FULL;
      band_g    = edsc_pkg::LVL_ZERO;
      band_b    = edsc_pkg::LVL_ZERO;
    end else if (cm < CM_W'(edge_yellow)) begin
      band_r = edsc_pkg::LVL_FULL;
      band_g = edsc_pkg::LVL_FULL;
      band_b = edsc_pkg::LVL_ZERO;
    end else if (cm < CM_W'(edge_green)) begin
      band_r = edsc_pkg::LVL_ZERO;
      band_g = edsc_pkg::LVL_FULL;
      band_b = edsc_pkg::LVL_ZERO;
    end else if (cm < CM_W'(edge_blue)) begin
      band_r = edsc_pkg::LVL_ZERO;
      band_g = edsc_pkg::LVL_ZERO;
      band_b = edsc_pkg::LVL_FULL;
    end
  end

  // ring memory; read and write never meet since beats do not overlap
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= ring[write_slot];
    end
    if (ring_we) begin
      ring[write_slot] <= dist_q;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_off    <= edsc_pkg::RST_EDGE_OFF;
      edge_red    <= edsc_pkg::RST_EDGE_RED;
      edge_ramp   <= edsc_pkg::RST_EDGE_RAMP;
      edge_yellow <= edsc_pkg::RST_EDGE_YELLOW;
      edge_green  <= edsc_pkg::RST_EDGE_GREEN;
      edge_blue   <= edsc_pkg::RST_EDGE_BLUE;
      green_peak  <= edsc_pkg::RST_GREEN_PEAK;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        edsc_pkg::REG_EDGE_OFF:    edge_off    <= cfg_data;
        edsc_pkg::REG_EDGE_RED:    edge_red    <= cfg_data;
        edsc_pkg::REG_EDGE_RAMP:   edge_ramp   <= cfg_data;
        edsc_pkg::REG_EDGE_YELLOW: edge_yellow <= cfg_data;
        edsc_pkg::REG_EDGE_GREEN:  edge_green  <= cfg_data;
        edsc_pkg::REG_EDGE_BLUE:   edge_blue   <= cfg_data;
        edsc_pkg::REG_GREEN_PEAK:  green_peak  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ring_valid  <= '0;
      rd_valid    <= 1'b0;
      write_slot  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            dist_q   <= scale_prod[edsc_pkg::PROD_W-1:edsc_pkg::FRAC_W];
            rd_valid <= ring_valid[write_slot];
            state    <= S_UPD;
          end
        end
        S_UPD: begin
          running_sum            <= sum_next;
          ring_valid[write_slot] <= 1'b1;
          write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
          state      <= S_DAVG;
        end
        S_DAVG: begin
          avg_q <= avg_prod[AVG_SH +: DIST_W];
          state <= S_BAND;
        end
        S_BAND: begin
          red_q       <= band_r;
          grn_q       <= band_g;
          blu_q       <= band_b;
          ramp_diff_q <= cm[7:0] - edge_red;   // cm < edge_ramp here, fits 8 bits
          span_q      <= edge_ramp - edge_red;
          state       <= band_ramp ? S_RAMP : S_DONE;
        end
        S_RAMP: begin
          state <= S_DRAMP;
        end
        S_DRAMP: begin
          if (div_done) begin
            grn_q <= div_quo[7:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            smoothed_q8 <= avg_q;
            red         <= red_q;
            green       <= grn_q;
            blue        <= blu_q;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `EDSC_CHK_NEXT(a_busy_after_accept, in_acc, in_stall, "input not stalled after accept")
  `EDSC_CHK_SAME(a_div_done_owned, div_done, state == S_DRAMP, "divider result with no owner")
  `EDSC_CHK_SAME(a_slot_range, 1'b1, {1'b0, write_slot} < (SLOT_W+1)'(WINDOW), "bad write slot")
  `EDSC_CHK_SAME(a_no_launch_busy, div_ctl.start, !div_done, "divider launched over result")

endmodule

### src/edsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, 8-bit divisor.
// Depends on edsc_pkg (div_ctl_t, STEP_W).
module edsc_div #(
  parameter int DVD_W = 27
) (
  input  logic                   clk,
  input  logic                   rst,
  input  edsc_pkg::div_ctl_t     ctl,
  input  logic [DVD_W-1:0]       dividend,
  input  logic [7:0]             divisor,
  output logic [DVD_W-1:0]       quotient,
  output logic                   done
);

  // dividend shifts out the top while quotient bits shift in at the bottom;
  // a dividend left-aligned and run for n steps leaves its quotient in [n-1:0]
  logic [DVD_W-1:0]          quo;
  logic [7:0]                rem;
  logic [edsc_pkg::STEP_W-1:0] cnt;
  logic                      busy;
  logic [8:0]                rem_sh;
  logic [8:0]                rem_diff;
  logic                      ge;

  assign rem_sh   = {rem, quo[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= ctl.steps;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DVD_W-2:0], ge};
        rem <= ge ? rem_diff[7:0] : rem_sh[7:0];
        cnt <= cnt - 1'b1;
        if (cnt == edsc_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
